[rtl/core/pps_pkg.sv]
// shared constants, codes and types for the preemptive priority scheduler
package pps_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int BURST_W       = 16;
  localparam int PRIO_W        = 8;
  localparam int TIME_W        = 16;
  localparam int JOB_NUM_W     = 5;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  typedef struct packed {
    logic en;
    logic all;
  } wr_ctl_t;

endpackage

[rtl/core/pps_if.sv]
// valid/ready channel interfaces for item and result beats
interface pps_item_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [pps_pkg::BURST_W-1:0] burst;
  logic [pps_pkg::PRIO_W-1:0]  prio;
  logic [pps_pkg::TIME_W-1:0]  arrival;

  modport source (output valid, cmd, burst, prio, arrival, input ready);
  modport sink   (input valid, cmd, burst, prio, arrival, output ready);
endinterface

interface pps_res_if;
  logic                          valid;
  logic                          ready;
  logic                          busy_res;
  logic [pps_pkg::JOB_NUM_W-1:0] job_number;
  logic [pps_pkg::TIME_W-1:0]    tick_time;
  logic                          job_done;

  modport source (output valid, busy_res, job_number, tick_time, job_done, input ready);
  modport sink   (input valid, busy_res, job_number, tick_time, job_done, output ready);
endinterface

[rtl/core/pps_table.sv]
// job table memory: one write port, one registered read port
module pps_table #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
  parameter int IDX_W     = $clog2(MAX_PROCS)
) (
  input  logic                        clk,
  input  pps_pkg::wr_ctl_t            wr,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [pps_pkg::BURST_W-1:0] wr_rem,
  input  logic [pps_pkg::PRIO_W-1:0]  wr_prio,
  input  logic [pps_pkg::TIME_W-1:0]  wr_arr,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [pps_pkg::BURST_W-1:0] rd_rem,
  output logic [pps_pkg::PRIO_W-1:0]  rd_prio,
  output logic [pps_pkg::TIME_W-1:0]  rd_arr
);
  import pps_pkg::*;

  logic [BURST_W-1:0] rem_mem  [MAX_PROCS];
  logic [PRIO_W-1:0]  prio_mem [MAX_PROCS];
  logic [TIME_W-1:0]  arr_mem  [MAX_PROCS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      rem_mem[wr_addr] <= wr_rem;
      if (wr.all) begin
        prio_mem[wr_addr] <= wr_prio;
        arr_mem[wr_addr]  <= wr_arr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rem  <= rem_mem[rd_addr];
      rd_prio <= prio_mem[rd_addr];
      rd_arr  <= arr_mem[rd_addr];
    end
  end

endmodule

[rtl/core/pps_cmp.sv]
// candidate versus current best compare unit used once per scanned entry
module pps_cmp (
  input  logic                        found,
  input  logic [pps_pkg::TIME_W-1:0]  now,
  input  logic [pps_pkg::BURST_W-1:0] cand_rem,
  input  logic [pps_pkg::PRIO_W-1:0]  cand_prio,
  input  logic [pps_pkg::TIME_W-1:0]  cand_arr,
  input  logic [pps_pkg::PRIO_W-1:0]  best_prio,
  input  logic [pps_pkg::TIME_W-1:0]  best_arr,
  output logic                        take
);
  import pps_pkg::*;

  logic ready_job;
  logic better;

  always_comb begin
    ready_job = (cand_rem != '0) && (cand_arr <= now);
    better    = (cand_prio < best_prio) ||
                ((cand_prio == best_prio) && (cand_arr < best_arr));
    take      = ready_job && (!found || better);
  end

endmodule

[rtl/core/preemptive_priority_scheduler.sv]
// preemptive priority scheduler top level: sequencer, scan pipeline and result register
// an add beat that fits is written on acceptance; the next item is accepted in the following cycle
// a tick scans one entry per cycle through the shared compare unit and single read port
// a tick reads and compares each entry in scan, then the finish state loads the result register
// finish waits while an earlier result is not taken; no item is accepted until the tick is through
// synchronous reset clears time, job count and control; table contents stay undefined until added
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
  input logic clk,
  input logic rst,
  pps_item_if.sink  item,
  pps_res_if.source res
);
  import pps_pkg::*;

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  state_t             state;
  logic [CNT_W-1:0]   job_count;
  logic [TIME_W-1:0]  now;
  logic [CNT_W-1:0]   iss;
  logic               chk_valid;
  logic [IDX_W-1:0]   chk_idx;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [BURST_W-1:0] best_rem;
  logic [PRIO_W-1:0]  best_prio;
  logic [TIME_W-1:0]  best_arr;
  logic               out_valid;
  logic               out_busy;
  logic [JOB_NUM_W-1:0] out_num;
  logic [TIME_W-1:0]  out_time;
  logic               out_done;

  wr_ctl_t            wr;
  logic [IDX_W-1:0]   wr_addr;
  logic [BURST_W-1:0] wr_rem;
  logic               rd_en;
  logic [BURST_W-1:0] rd_rem;
  logic [PRIO_W-1:0]  rd_prio;
  logic [TIME_W-1:0]  rd_arr;
  logic               take;

  logic item_fire;
  logic add_ok;
  logic can_load;
  logic scan_done;

  always_comb begin
    item.ready = (state == ST_IDLE);
    item_fire  = item.valid && item.ready;
    add_ok     = (item.burst != '0) && (job_count < CNT_W'(MAX_PROCS));
    can_load   = !out_valid || res.ready;
    rd_en      = (state == ST_SCAN) && (iss < job_count);
    scan_done  = (iss == job_count) && !chk_valid;
    wr.all     = (state == ST_IDLE);
    wr.en      = (item_fire && (item.cmd == CMD_ADD) && add_ok) ||
                 ((state == ST_FINISH) && can_load && found);
    wr_addr    = (state == ST_IDLE) ? job_count[IDX_W-1:0] : best_idx;
    wr_rem     = (state == ST_IDLE) ? item.burst : best_rem - BURST_W'(1);
  end

  pps_table #(
    .MAX_PROCS (MAX_PROCS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_rem  (wr_rem),
    .wr_prio (item.prio),
    .wr_arr  (item.arrival),
    .rd_en   (rd_en),
    .rd_addr (iss[IDX_W-1:0]),
    .rd_rem  (rd_rem),
    .rd_prio (rd_prio),
    .rd_arr  (rd_arr)
  );

  pps_cmp u_cmp (
    .found     (found),
    .now       (now),
    .cand_rem  (rd_rem),
    .cand_prio (rd_prio),
    .cand_arr  (rd_arr),
    .best_prio (best_prio),
    .best_arr  (best_arr),
    .take      (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      job_count <= '0;
      now       <= '0;
      iss       <= '0;
      chk_valid <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_FINISH) && can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      chk_valid <= rd_en;
      unique case (state)
        ST_IDLE: begin
          if (item_fire) begin
            if (item.cmd == CMD_ADD) begin
              if (add_ok) begin
                job_count <= job_count + CNT_W'(1);
              end
            end else begin
              iss   <= '0;
              found <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            iss <= iss + CNT_W'(1);
          end
          if (chk_valid && take) begin
            found <= 1'b1;
          end
          if (scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (can_load) begin
            if (now != '1) begin
              now <= now + TIME_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // scan datapath and result payload
  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_idx <= iss[IDX_W-1:0];
    end
    if (chk_valid && take) begin
      best_idx  <= chk_idx;
      best_rem  <= rd_rem;
      best_prio <= rd_prio;
      best_arr  <= rd_arr;
    end
    if ((state == ST_FINISH) && can_load) begin
      out_time <= now;
      out_busy <= found;
      out_num  <= found ? JOB_NUM_W'(best_idx) + JOB_NUM_W'(1) : '0;
      out_done <= found && (best_rem == BURST_W'(1));
    end
  end

  always_comb begin
    res.valid      = out_valid;
    res.busy_res   = out_busy;
    res.job_number = out_num;
    res.tick_time  = out_time;
    res.job_done   = out_done;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    job_count <= CNT_W'(MAX_PROCS))
    else $error("job count beyond table size");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.busy_res) |-> (res.job_number == '0) && !res.job_done)
    else $error("idle result carries a job");

  a_time_step: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FINISH) && can_load) |=>
      (now == $past(now) + TIME_W'(1)) || (now == '1))
    else $error("time did not advance after tick");

  a_check_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (state == ST_SCAN))
    else $error("table read data outside scan");

endmodule

[sim/pps_checker.sv]
// scoreboard for the scheduler: predicts tick results from item beats and checks result beats
module pps_checker (
  input  logic clk,
  input  logic rst,
  pps_item_if  item,
  pps_res_if   res,
  output int   fails,
  output int   pending
);
  import pps_pkg::*;

  localparam int SLOTS = MAX_PROCS_DEF;

  typedef struct packed {
    logic                 busy_res;
    logic [JOB_NUM_W-1:0] job_number;
    logic [TIME_W-1:0]    tick_time;
    logic                 job_done;
  } tick_out_t;

  logic [TIME_W-1:0]  sched_now;
  int                 jobs_held;
  logic [BURST_W-1:0] left_burst [SLOTS];
  logic [PRIO_W-1:0]  job_pri    [SLOTS];
  logic [TIME_W-1:0]  job_arr    [SLOTS];
  tick_out_t          due_ticks[$];
  tick_out_t          want;

  initial begin
    fails   = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    fails++;
  endtask

  // lowest priority value wins, then earliest arrival, then lowest slot
  function automatic tick_out_t schedule_tick();
    tick_out_t r;
    int        pick;
    pick = -1;
    for (int i = 0; i < jobs_held; i++) begin
      if (left_burst[i] != '0 && job_arr[i] <= sched_now) begin
        if (pick < 0 || job_pri[i] < job_pri[pick] ||
            (job_pri[i] == job_pri[pick] && job_arr[i] < job_arr[pick])) begin
          pick = i;
        end
      end
    end
    r.tick_time = sched_now;
    if (pick >= 0) begin
      left_burst[pick] = left_burst[pick] - 1'b1;
      r.busy_res       = 1'b1;
      r.job_number     = JOB_NUM_W'(pick + 1);
      r.job_done       = (left_burst[pick] == '0);
    end else begin
      r.busy_res   = 1'b0;
      r.job_number = '0;
      r.job_done   = 1'b0;
    end
    if (sched_now != '1) sched_now = sched_now + 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sched_now = '0;
      jobs_held = 0;
      due_ticks.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (due_ticks.size() == 0) begin
          report($sformatf("unexpected result beat: busy %0d job %0d time %0d done %0d",
                           res.busy_res, res.job_number, res.tick_time, res.job_done));
        end else begin
          want = due_ticks.pop_front();
          if (res.busy_res !== want.busy_res)
            report($sformatf("tick %0d busy_res got %0d want %0d",
                             want.tick_time, res.busy_res, want.busy_res));
          if (res.job_number !== want.job_number)
            report($sformatf("tick %0d job_number got %0d want %0d",
                             want.tick_time, res.job_number, want.job_number));
          if (res.tick_time !== want.tick_time)
            report($sformatf("tick %0d tick_time got %0d",
                             want.tick_time, res.tick_time));
          if (res.job_done !== want.job_done)
            report($sformatf("tick %0d job_done got %0d want %0d",
                             want.tick_time, res.job_done, want.job_done));
        end
      end
      if (item.valid && item.ready) begin
        if (item.cmd == CMD_TICK) begin
          due_ticks = {due_ticks, schedule_tick()};
        end else if (item.burst != '0 && jobs_held < SLOTS) begin
          left_burst[jobs_held] = item.burst;
          job_pri[jobs_held]    = item.prio;
          job_arr[jobs_held]    = item.arrival;
          jobs_held++;
        end
      end
    end
    pending = due_ticks.size();
  end

endmodule

[sim/tb_top.sv]
// testbench top for the scheduler: clock, reset, item and result traffic, verdict
module tb_top;
  import pps_pkg::*;

  logic clk;
  logic rst;
  int   send_idle = 13;
  int   recv_idle = 83;
  int   fails;
  int   pending;
  int   ticks_sent;
  int   jobs_loaded;
  int   last_arrival;

  pps_item_if item_ch ();
  pps_res_if  res_ch ();

  preemptive_priority_scheduler dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .res  (res_ch)
  );

  pps_checker chk (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .res     (res_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    #60000000;
    $display("FAIL preemptive_priority_scheduler");
    $finish;
  end

  task automatic send_beat(input logic cmd, input logic [BURST_W-1:0] burst,
                           input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] arrival);
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.cmd     <= cmd;
    item_ch.burst   <= burst;
    item_ch.prio    <= prio;
    item_ch.arrival <= arrival;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_TICK) ticks_sent++;
    else if (burst != '0 && jobs_loaded < MAX_PROCS_DEF) jobs_loaded++;
  endtask

  task automatic send_random(input int count);
    int                 placed;
    int                 now_est;
    int                 later;
    logic [BURST_W-1:0] b;
    logic [PRIO_W-1:0]  p;
    logic [TIME_W-1:0]  a;
    placed = 0;
    while (placed < count) begin
      now_est = (ticks_sent > 65535) ? 65535 : ticks_sent;
      if (jobs_loaded < MAX_PROCS_DEF && $urandom_range(29) == 0) begin
        if ($urandom_range(9) == 0) begin
          b = BURST_W'($urandom_range(65535, 1));
          p = PRIO_W'($urandom_range(255, 200));
        end else begin
          b = BURST_W'($urandom_range(40, 1));
          p = ($urandom_range(3) == 0) ? PRIO_W'($urandom_range(255)) :
                                         PRIO_W'($urandom_range(7));
        end
        later = now_est + $urandom_range(80);
        case ($urandom_range(3))
          0: a = TIME_W'($urandom_range(now_est));
          1: a = TIME_W'(last_arrival);
          default: a = (later > 65535) ? '1 : TIME_W'(later);
        endcase
        last_arrival = a;
        send_beat(CMD_ADD, b, p, a);
        placed++;
      end else if ($urandom_range(19) == 0) begin
        // zero burst, or anything once the table is full
        b = (jobs_loaded < MAX_PROCS_DEF) ? '0 : BURST_W'($urandom);
        send_beat(CMD_ADD, b, PRIO_W'($urandom), TIME_W'($urandom));
      end else begin
        send_beat(CMD_TICK, BURST_W'($urandom), PRIO_W'($urandom), TIME_W'($urandom));
        placed++;
      end
    end
  endtask

  initial begin
    item_ch.valid   = 1'b0;
    item_ch.cmd     = CMD_ADD;
    item_ch.burst   = '0;
    item_ch.prio    = '0;
    item_ch.arrival = '0;
    rst             = 1'b1;
    ticks_sent      = 0;
    jobs_loaded     = 0;
    last_arrival    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle tick on an empty table, then a zero burst add
    send_beat(CMD_TICK, '0, '0, '0);
    send_beat(CMD_ADD, '0, '0, '0);
    // longest job at the worst priority, ready only once time saturates
    send_beat(CMD_ADD, '1, '1, '1);
    // equal priorities: earlier arrival first, then lower job number
    send_beat(CMD_ADD, 16'd2, 8'd5, 16'd3);
    send_beat(CMD_ADD, 16'd1, 8'd5, 16'd2);
    send_beat(CMD_ADD, 16'd2, 8'd5, 16'd2);
    // top priority job preempting at tick 6
    send_beat(CMD_ADD, 16'd3, 8'd0, 16'd6);
    repeat (10) send_beat(CMD_TICK, '1, '1, '1);
    // arrival already in the past
    send_beat(CMD_ADD, 16'd1, 8'd0, 16'd0);
    repeat (2) send_beat(CMD_TICK, '0, '0, '0);

    send_random(383);
    send_idle = 83;
    recv_idle = 13;
    send_random(383);
    send_idle = 0;
    recv_idle = 0;
    send_random(384);
    item_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fails == 0) $display("PASS preemptive_priority_scheduler");
    else $display("FAIL preemptive_priority_scheduler");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pps_pkg.sv
rtl/core/pps_if.sv
rtl/core/pps_table.sv
rtl/core/pps_cmp.sv
rtl/core/preemptive_priority_scheduler.sv
sim/pps_checker.sv
sim/tb_top.sv
